### hw/rtl/thermocouple_frame_reader_assert.svh
// Assertion macros shared by the thermocouple frame reader RTL.
`ifndef THERMOCOUPLE_FRAME_READER_ASSERT_SVH
`define THERMOCOUPLE_FRAME_READER_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked while out of reset.
`define TFR_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked while out of reset.
`define TFR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TFR_ASSERT_SAME(label, clk, rstn, ante, cons, msg)
`define TFR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif

`endif

### hw/rtl/tfr_pkg.sv
package tfr_pkg;

    localparam int TIME_W      = 32;
    localparam int FRAME_W     = 16;
    localparam int TEMP_W      = 12;
    localparam int CONV_W      = 16;
    localparam int FAULT_W     = 3;
    localparam int TEMP_LSB    = 3;
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 16;
    localparam int M_TUSER_W   = 2;

    localparam logic [CONV_W-1:0] CONV_MS_RESET = 16'd220;

    // Per-channel state entry.
    typedef struct packed {
        logic [TIME_W-1:0]        last_time;
        logic signed [TEMP_W-1:0] held;
    } tfr_entry_t;

    // One result item.
    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature_q;
        logic                     healthy;
        logic                     frame_used;
    } tfr_result_t;

endpackage

### hw/rtl/tfr_state_mem.sv
module tfr_state_mem #(
    parameter int DEPTH  = 2,
    parameter int ADDR_W = 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output tfr_pkg::tfr_entry_t rd_data,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  tfr_pkg::tfr_entry_t wr_data
);
    import tfr_pkg::*;

    tfr_entry_t       state_mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;
    tfr_entry_t       rd_data_reg;
    logic             rd_in_range;

    assign rd_in_range = (32'(rd_addr) < DEPTH);
    assign rd_data     = rd_data_reg;

    // Mark an entry valid on its first write; unwritten entries read as zero.
    always_comb begin
        valid_next = valid_reg;
        if (wr_en) begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            state_mem[wr_addr] <= wr_data;
        end
    end

    // Registered read; forward a write to the same entry in the same cycle.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_data_reg <= wr_data;
            end else if (rd_in_range && valid_reg[rd_addr]) begin
                rd_data_reg <= state_mem[rd_addr];
            end else begin
                rd_data_reg <= '0;
            end
        end
    end

endmodule

### hw/rtl/tfr_update.sv
module tfr_update (
    input  logic                        in_range,
    input  logic [tfr_pkg::TIME_W-1:0]  now_ms,
    input  logic [tfr_pkg::FRAME_W-1:0] raw_frame,
    input  logic [tfr_pkg::CONV_W-1:0]  conv_ms,
    input  tfr_pkg::tfr_entry_t         entry,
    output tfr_pkg::tfr_result_t        result,
    output logic                        wr_req,
    output tfr_pkg::tfr_entry_t         wr_entry
);
    import tfr_pkg::*;

    logic [TIME_W-1:0]        elapsed;
    logic                     used;
    logic                     fault;
    logic                     empty;
    logic signed [TEMP_W-1:0] decoded;
    logic signed [TEMP_W-1:0] temp_sel;

    assign elapsed = now_ms - entry.last_time;
    assign used    = (elapsed >= TIME_W'(conv_ms));
    assign fault   = (raw_frame[FAULT_W-1:0] != '0);
    assign empty   = (raw_frame == '0);
    assign decoded = raw_frame[TEMP_LSB +: TEMP_W];

    // Take the new reading only from a clean, non-empty frame.
    assign temp_sel = (used && !fault && !empty) ? decoded : entry.held;

    always_comb begin
        result.temperature_q = in_range ? temp_sel : '0;
        result.healthy       = in_range && !(used && fault);
        result.frame_used    = in_range && used;
    end

    assign wr_req             = in_range && used;
    assign wr_entry.last_time = now_ms;
    assign wr_entry.held      = temp_sel;

endmodule

### hw/rtl/thermocouple_frame_reader.sv
// A request waits in stage 1 for its state read, then in the output register. Throughput: one
// request per cycle unless m_tready stalls the output, set by the single read-modify-write of
// the state memory; a written entry is forwarded to a same-channel read in the same cycle.
// Reset: synchronous, active low; conv_ms returns to 220 and all channel state reads as zero
// at once (per-entry valid bits), so requests are taken from the first cycle after reset.
module thermocouple_frame_reader #(
    parameter int CHANNELS = 2
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration: conv_ms write.
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tfr_pkg::CONV_W-1:0]    cfg_data,
    // Request stream.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tfr_pkg::S_TDATA_W-1:0] s_tdata,   // [31:0] now_ms, [47:32] raw_frame
    input  logic                          s_tuser,   // [0] channel
    // Result stream.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tfr_pkg::M_TDATA_W-1:0] m_tdata,   // [11:0] temperature_q, [15:12] zero
    output logic [tfr_pkg::M_TUSER_W-1:0] m_tuser    // [0] healthy, [1] frame_used
);
    import tfr_pkg::*;

    `include "thermocouple_frame_reader_assert.svh"

    localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Configuration register.
    logic [CONV_W-1:0]  conv_ms_reg;

    // Stage 1: request waiting on its state read.
    logic               s1_valid_reg;
    logic               s1_channel_reg;
    logic [TIME_W-1:0]  s1_now_reg;
    logic [FRAME_W-1:0] s1_frame_reg;

    // Output register.
    logic               m_valid_reg;
    tfr_result_t        m_result_reg;

    logic               s_xfer;
    logic               advance;
    logic               s1_fire;
    logic               s1_in_range;
    tfr_entry_t         rd_entry;
    tfr_entry_t         wr_entry;
    tfr_result_t        s1_result;
    logic               wr_req;
    logic               mem_wr_en;

    // Config writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            conv_ms_reg <= CONV_MS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            conv_ms_reg <= cfg_data;
        end
    end

    // Advance the output register whenever it is empty or being drained.
    assign advance  = !m_valid_reg || m_tready;
    assign s1_fire  = s1_valid_reg && advance;
    assign s_tready = !s1_valid_reg || advance;
    assign s_xfer   = s_tvalid && s_tready;

    assign s1_in_range = (32'(s1_channel_reg) < CHANNELS);
    assign mem_wr_en   = s1_fire && wr_req;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    // Hold the request payload while stage 1 is stalled.
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            s1_channel_reg <= s_tuser;
            s1_now_reg     <= s_tdata[TIME_W-1:0];
            s1_frame_reg   <= s_tdata[TIME_W +: FRAME_W];
        end
    end

    tfr_state_mem #(
        .DEPTH  (CHANNELS),
        .ADDR_W (ADDR_W)
    ) u_state_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_xfer),
        .rd_addr (ADDR_W'(s_tuser)),
        .rd_data (rd_entry),
        .wr_en   (mem_wr_en),
        .wr_addr (ADDR_W'(s1_channel_reg)),
        .wr_data (wr_entry)
    );

    tfr_update u_update (
        .in_range  (s1_in_range),
        .now_ms    (s1_now_reg),
        .raw_frame (s1_frame_reg),
        .conv_ms   (conv_ms_reg),
        .entry     (rd_entry),
        .result    (s1_result),
        .wr_req    (wr_req),
        .wr_entry  (wr_entry)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            m_result_reg <= s1_result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-TEMP_W){1'b0}}, m_result_reg.temperature_q};
    assign m_tuser  = {m_result_reg.frame_used, m_result_reg.healthy};

    `TFR_ASSERT_SAME(a_wr_in_range, aclk, aresetn, mem_wr_en, s1_in_range && s1_result.frame_used, "state write for a request that did not read its frame")
    `TFR_ASSERT_SAME(a_out_of_range_zero, aclk, aresetn, s1_valid_reg && !s1_in_range, s1_result == '0, "out-of-range channel gave a nonzero result")
    `TFR_ASSERT_SAME(a_fault_used, aclk, aresetn, s1_valid_reg && s1_in_range && !s1_result.healthy, s1_result.frame_used, "unhealthy result without a frame read")
    `TFR_ASSERT_NEXT(a_fire_loads_out, aclk, aresetn, s1_fire, m_valid_reg, "request left stage 1 without reaching the output register")

endmodule

### dv/thermocouple_frame_reader_tb.sv
module thermocouple_frame_reader_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tfr_pkg::*;

    localparam int CHANNELS     = 2;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_CYCLES = 8;

    localparam logic [FAULT_W-1:0] NO_FAULT        = '0;
    localparam logic [FAULT_W-1:0] FAULT_OPEN      = 3'b001;
    localparam logic [FAULT_W-1:0] FAULT_SHORT_GND = 3'b010;
    localparam logic [FAULT_W-1:0] FAULT_SHORT_VCC = 3'b100;
    localparam logic [FAULT_W-1:0] FAULT_ALL       = 3'b111;
    localparam logic [FRAME_W-1:0] FRAME_NOT_READY = '0;
    localparam logic [TEMP_W-1:0]  TEMP_MAX_POS    = 12'h7FF;
    localparam logic [TEMP_W-1:0]  TEMP_MAX_NEG    = 12'h800;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CONV_W-1:0]    cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;   // [31:0] now_ms, [47:32] raw_frame
    logic                 s_tuser   = 1'b0; // [0] channel
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // [11:0] temperature_q, [15:12] zero
    logic [M_TUSER_W-1:0] m_tuser;          // [0] healthy, [1] frame_used

    // Model state: one entry per channel plus the conversion interval.
    tfr_entry_t        chan_state [CHANNELS];
    logic [CONV_W-1:0] conv_ms_model = CONV_MS_RESET;

    tfr_result_t pending_readings[$];
    tfr_result_t want;
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          tx_gap_pct     = 0;
    int          rx_stall_pct   = 0;

    thermocouple_frame_reader #(
        .CHANNELS(CHANNELS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        for (int i = 0; i < CHANNELS; i++) begin
            chan_state[i] = '0;
        end
    end

    // Predict one reading and advance the channel state as the block would.
    function automatic tfr_result_t predict_reading(input bit ch,
                                                    input logic [TIME_W-1:0] now,
                                                    input logic [FRAME_W-1:0] frame);
        tfr_result_t        r;
        logic [TIME_W-1:0]  elapsed;
        elapsed         = now - chan_state[ch].last_time;
        r.temperature_q = chan_state[ch].held;
        r.healthy       = 1'b1;
        r.frame_used    = 1'b0;
        if (elapsed >= TIME_W'(conv_ms_model)) begin
            r.frame_used              = 1'b1;
            chan_state[ch].last_time  = now;
            if (frame[FAULT_W-1:0] != NO_FAULT) begin
                r.healthy = 1'b0;
            end else if (frame != FRAME_NOT_READY) begin
                chan_state[ch].held = frame[TEMP_LSB +: TEMP_W];
                r.temperature_q     = frame[TEMP_LSB +: TEMP_W];
            end
        end
        return r;
    endfunction

    function automatic logic [FRAME_W-1:0] frame_of(input bit top,
                                                    input logic [TEMP_W-1:0] temp,
                                                    input logic [FAULT_W-1:0] fault);
        return {top, temp, fault};
    endfunction

    // Offer one request, hold it until the transfer, then record its expected reading.
    task automatic send_request(input bit ch, input logic [TIME_W-1:0] now,
                                input logic [FRAME_W-1:0] frame);
        while ($urandom_range(0, 99) < tx_gap_pct) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = {frame, now};
        s_tuser  = ch;
        do @(posedge aclk); while (!s_tready);
        pending_readings.push_back(predict_reading(ch, now, frame));
    endtask

    // Stop offering and let every outstanding reading come back.
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_readings.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_conv(input logic [CONV_W-1:0] value);
        drain_results();
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        conv_ms_model = value;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Reset state: interval 220, all channels read at time zero.
    task automatic test_reset_state();
        send_request(1'b0, 32'd5, frame_of(1'b0, 12'h123, NO_FAULT));
        send_request(1'b1, 32'd219, frame_of(1'b0, 12'h456, NO_FAULT));
        send_request(1'b0, 32'd220, frame_of(1'b0, TEMP_MAX_POS, NO_FAULT));
        send_request(1'b1, 32'hFFFF_FFFF, frame_of(1'b1, TEMP_MAX_NEG, NO_FAULT));
        send_request(1'b0, 32'd300, frame_of(1'b0, 12'h001, NO_FAULT));
    endtask

    // Each fault flag, a not-ready frame, a frame with only the ignored top bit.
    task automatic test_fault_flags();
        send_request(1'b0, 32'd440, frame_of(1'b0, 12'h3A5, FAULT_OPEN));
        send_request(1'b0, 32'd660, frame_of(1'b1, 12'h5A3, FAULT_SHORT_GND));
        send_request(1'b0, 32'd880, frame_of(1'b0, 12'hFFF, FAULT_SHORT_VCC));
        send_request(1'b0, 32'd1100, FRAME_NOT_READY);
        send_request(1'b0, 32'd1320, frame_of(1'b1, 12'h000, NO_FAULT));
        send_request(1'b0, 32'd1540, frame_of(1'b1, 12'hFFF, FAULT_ALL));
        send_request(1'b0, 32'd1760, frame_of(1'b0, 12'h001, NO_FAULT));
    endtask

    // Small forward step across the wrap, then a step backwards.
    task automatic test_time_backwards();
        send_request(1'b1, 32'd0, frame_of(1'b0, 12'h222, NO_FAULT));
        send_request(1'b1, 32'd500, frame_of(1'b0, 12'h333, NO_FAULT));
        send_request(1'b1, 32'd100, frame_of(1'b1, 12'hC00, NO_FAULT));
    endtask

    // Zero interval reads every time; the widest interval needs its full span.
    task automatic test_conv_extremes();
        write_conv('0);
        send_request(1'b0, 32'd1760, frame_of(1'b0, 12'h0F0, NO_FAULT));
        send_request(1'b0, 32'd1760, frame_of(1'b0, 12'h0F1, NO_FAULT));
        write_conv('1);
        send_request(1'b0, 32'd1760 + 32'd65534, frame_of(1'b0, 12'h700, NO_FAULT));
        send_request(1'b0, 32'd1760 + 32'd65535, frame_of(1'b0, 12'h701, NO_FAULT));
    endtask

    // Mostly a clock that moves forward around the interval, with jumps and rewinds.
    task automatic run_random_traffic(input int count, input int gap_pct,
                                      input int stall_pct, input logic [CONV_W-1:0] conv);
        logic [TIME_W-1:0]  clock_ms;
        logic [TIME_W-1:0]  span;
        logic [FRAME_W-1:0] frame;
        int                 pick;
        write_conv(conv);
        tx_gap_pct   = gap_pct;
        rx_stall_pct = stall_pct;
        clock_ms     = $urandom;
        span         = TIME_W'(conv) / 2 + 2;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 85) begin
                clock_ms += $urandom_range(0, span);
            end else if (pick < 93) begin
                clock_ms = $urandom;
            end else begin
                clock_ms -= $urandom_range(1, span);
            end
            frame = FRAME_W'($urandom);
            pick  = $urandom_range(0, 99);
            if (pick < 50) begin
                frame[FAULT_W-1:0] = NO_FAULT;
            end else if (pick < 70) begin
                frame[FAULT_W-1:0] = FAULT_W'($urandom_range(1, 7));
            end else if (pick < 80) begin
                frame = FRAME_NOT_READY;
            end
            send_request(1'($urandom_range(0, 1)), clock_ms, frame);
        end
    endtask

    always @(negedge aclk) begin
        m_tready = ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // Compare every result transfer against the oldest pending reading.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_readings.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("unexpected reading: tdata %h tuser %b", m_tdata, m_tuser);
                end
            end else begin
                want = pending_readings.pop_front();
                if (m_tdata !== {{(M_TDATA_W-TEMP_W){1'b0}}, want.temperature_q} ||
                    m_tuser[0] !== want.healthy || m_tuser[1] !== want.frame_used) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("reading mismatch: temp exp %h got %h, healthy exp %b got %b, used exp %b got %b",
                                 want.temperature_q, m_tdata, want.healthy, m_tuser[0],
                                 want.frame_used, m_tuser[1]);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        tx_gap_pct   = 12;
        rx_stall_pct = 48;
        test_reset_state();
        test_fault_flags();
        test_time_backwards();
        test_conv_extremes();

        run_random_traffic(620, 12, 48, CONV_W'($urandom_range(1, 600)));
        run_random_traffic(620, 48, 12, CONV_W'($urandom_range(0, 65535)));
        run_random_traffic(620, 0, 0, CONV_W'($urandom_range(0, 60)));
        drain_results();

        if (mismatch_count == 0 && pending_readings.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
